@@ rtl/core/fcct_pkg.sv @@
// Shared types and constants for the frustum corner cull test core.
// Used by the multiplier unit and the top level.
// No dependencies.
package fcct_pkg;

  localparam int FRAC_BITS_DEF = 16;

  // Matrix layout: 4 rows by 3 columns, rows 0..2 linear, row 3 translation
  localparam int MAT_COLS  = 3;
  localparam int LIN_COUNT = 9;
  localparam int ELEM_COUNT = 12;

  // Input actions
  localparam logic [1:0] ACT_VIEW   = 2'd0;
  localparam logic [1:0] ACT_WORLD  = 2'd1;
  localparam logic [1:0] ACT_CORNER = 2'd2;

  // Configuration register indexes
  localparam logic [1:0] CFG_NEAR    = 2'd0;
  localparam logic [1:0] CFG_FAR     = 2'd1;
  localparam logic [1:0] CFG_SLOPE_X = 2'd2;
  localparam logic [1:0] CFG_SLOPE_Y = 2'd3;

  localparam logic [30:0] NEAR_RST    = 31'd65536;
  localparam logic [30:0] FAR_RST     = 31'd65536000;
  localparam logic [30:0] SLOPE_X_RST = 31'd67271;
  localparam logic [30:0] SLOPE_Y_RST = 31'd37837;

  typedef enum logic [1:0] {
    OP_WORLD,
    OP_VIEW,
    OP_SLX,
    OP_SLY
  } op_kind_t;

  // Travels with each product through the shared multiplier
  typedef struct packed {
    logic     valid;
    op_kind_t kind;
    logic [1:0] col;
    logic [1:0] row;
  } mul_tag_t;

endpackage

@@ rtl/core/fcct_in_if.sv @@
// Input channel of the frustum corner cull test core: valid/ready plus
// one input word. Depends on nothing.
interface fcct_in_if;
  logic               valid;
  logic               ready;
  logic [1:0]         action;
  logic [3:0]         element_index;
  logic signed [31:0] element_value;
  logic signed [31:0] corner_x;
  logic signed [31:0] corner_y;
  logic signed [31:0] corner_z;
  logic               last_corner;

  modport source (
    output valid, action, element_index, element_value,
    output corner_x, corner_y, corner_z, last_corner,
    input  ready
  );
  modport sink (
    input  valid, action, element_index, element_value,
    input  corner_x, corner_y, corner_z, last_corner,
    output ready
  );
endinterface

@@ rtl/core/fcct_out_if.sv @@
// Result channel of the frustum corner cull test core: valid/ready plus
// the visible flag. Depends on nothing.
interface fcct_out_if;
  logic valid;
  logic ready;
  logic visible;

  modport source (output valid, visible, input ready);
  modport sink   (input valid, visible, output ready);
endinterface

@@ rtl/core/fcct_mul.sv @@
// Shared signed 32x32 multiplier with a registered product and the
// fixed-point floor shift applied on the way out. Uses fcct_pkg.
module fcct_mul #(
  parameter int FRAC_BITS = fcct_pkg::FRAC_BITS_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic signed [31:0]             op_a,
  input  logic signed [31:0]             op_b,
  input  fcct_pkg::mul_tag_t             tag_in,
  output logic signed [63-FRAC_BITS:0]   term,
  output fcct_pkg::mul_tag_t             tag_out
);

  logic signed [63:0] prod_r;
  fcct_pkg::mul_tag_t tag_r;

  always_ff @(posedge clk) begin
    prod_r <= op_a * op_b;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tag_r <= '0;
    end else begin
      tag_r <= tag_in;
    end
  end

  // dropping the low bits of a two's complement product is a floor divide
  assign term    = prod_r[63:FRAC_BITS];
  assign tag_out = tag_r;

endmodule

@@ rtl/core/frustum_corner_cull_test_core.sv @@
// Frustum corner cull test: world then view affine transform of each box
// corner, then near/far and slope tests, all through one shared multiplier.
// Matrix elements are written straight from each accepted input word; a
// corner holds off new input until its 20 multiplies and sequencing finish.
// The visible word is registered and raised in the last corner's finish step.
// rst_n is synchronous: restores register defaults and clears any_inside.
module frustum_corner_cull_test_core #(
  parameter int FRAC_BITS = fcct_pkg::FRAC_BITS_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  fcct_in_if.sink            in_chan,
  fcct_out_if.source         out_chan,
  input  logic               cfg_we,
  input  logic [1:0]         cfg_index,
  input  logic [30:0]        cfg_data
);

  localparam int TW = 64 - FRAC_BITS;  // shifted product width
  localparam int AW = TW + 2;          // three terms plus translation

  typedef enum logic [2:0] {
    S_IDLE,
    S_WORLD,
    S_VIEW,
    S_GAP,
    S_SLOPE,
    S_TAIL,
    S_FINISH
  } state_t;

  state_t state_r;
  logic [1:0] col_r, row_r;

  logic [30:0] near_r, far_r, slope_x_r, slope_y_r;

  logic signed [31:0] view_lin [fcct_pkg::LIN_COUNT];
  logic signed [31:0] view_tr  [fcct_pkg::MAT_COLS];
  logic signed [31:0] world_lin[fcct_pkg::LIN_COUNT];
  logic signed [31:0] world_tr [fcct_pkg::MAT_COLS];

  logic signed [31:0] p_r [fcct_pkg::MAT_COLS];
  logic signed [31:0] w_r [fcct_pkg::MAT_COLS];
  logic signed [31:0] v_r [fcct_pkg::MAT_COLS];
  logic               last_r;
  logic               any_inside_r;
  logic               okx_r, oky_r;
  logic signed [31:0] trans_r;
  logic signed [AW-1:0] acc_r;

  logic               out_valid_r, visible_r;

  logic               in_fire;
  logic [3:0]         lin_idx;
  logic [1:0]         tr_idx;
  logic signed [31:0] op_a, op_b;
  fcct_pkg::mul_tag_t issue_tag, mul_tag;
  logic signed [TW-1:0] term;

  logic signed [AW-1:0] acc_nxt;
  logic [31:0]          acc_sat;
  logic signed [31:0]   mag_sel;
  logic signed [32:0]   mag_ext;
  logic [32:0]          mag;
  logic signed [TW-1:0] mag_w;
  logic                 within_lim;
  logic                 in_view;
  logic                 any_nxt;
  logic                 out_free;

  assign in_chan.ready  = (state_r == S_IDLE);
  assign in_fire        = in_chan.valid && in_chan.ready;
  assign out_chan.valid   = out_valid_r;
  assign out_chan.visible = visible_r;
  assign out_free       = !out_valid_r || out_chan.ready;

  // ---------------- configuration ----------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      near_r    <= fcct_pkg::NEAR_RST;
      far_r     <= fcct_pkg::FAR_RST;
      slope_x_r <= fcct_pkg::SLOPE_X_RST;
      slope_y_r <= fcct_pkg::SLOPE_Y_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        fcct_pkg::CFG_NEAR:    near_r    <= cfg_data;
        fcct_pkg::CFG_FAR:     far_r     <= cfg_data;
        fcct_pkg::CFG_SLOPE_X: slope_x_r <= cfg_data;
        fcct_pkg::CFG_SLOPE_Y: slope_y_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // ---------------- matrix loads ----------------
  assign tr_idx = 2'(in_chan.element_index - 4'(fcct_pkg::LIN_COUNT));

  always_ff @(posedge clk) begin
    if (in_fire && in_chan.element_index < 4'(fcct_pkg::ELEM_COUNT)) begin
      if (in_chan.element_index < 4'(fcct_pkg::LIN_COUNT)) begin
        if (in_chan.action == fcct_pkg::ACT_VIEW)
          view_lin[in_chan.element_index] <= in_chan.element_value;
        else if (in_chan.action == fcct_pkg::ACT_WORLD)
          world_lin[in_chan.element_index] <= in_chan.element_value;
      end else begin
        if (in_chan.action == fcct_pkg::ACT_VIEW)
          view_tr[tr_idx] <= in_chan.element_value;
        else if (in_chan.action == fcct_pkg::ACT_WORLD)
          world_tr[tr_idx] <= in_chan.element_value;
      end
    end
  end

  // ---------------- multiplier issue ----------------
  assign lin_idx = 4'(row_r) * 4'(fcct_pkg::MAT_COLS) + 4'(col_r);

  always_comb begin
    issue_tag     = '0;
    issue_tag.col = col_r;
    issue_tag.row = row_r;
    op_a          = world_lin[lin_idx];
    op_b          = p_r[row_r];
    case (state_r)
      S_WORLD: begin
        issue_tag.valid = 1'b1;
        issue_tag.kind  = fcct_pkg::OP_WORLD;
      end
      S_VIEW: begin
        issue_tag.valid = 1'b1;
        issue_tag.kind  = fcct_pkg::OP_VIEW;
        op_a            = view_lin[lin_idx];
        op_b            = w_r[row_r];
      end
      S_SLOPE: begin
        issue_tag.valid = 1'b1;
        issue_tag.kind  = (row_r == 2'd0) ? fcct_pkg::OP_SLX : fcct_pkg::OP_SLY;
        op_a            = v_r[2];
        op_b            = (row_r == 2'd0) ? $signed({1'b0, slope_x_r})
                                          : $signed({1'b0, slope_y_r});
      end
      default: ;
    endcase
  end

  fcct_mul #(.FRAC_BITS(FRAC_BITS)) u_mul (
    .clk     (clk),
    .rst_n   (rst_n),
    .op_a    (op_a),
    .op_b    (op_b),
    .tag_in  (issue_tag),
    .term    (term),
    .tag_out (mul_tag)
  );

  // translation of the column is fetched alongside its first product
  always_ff @(posedge clk) begin
    if (row_r == 2'd0) begin
      if (state_r == S_WORLD) trans_r <= world_tr[col_r];
      else if (state_r == S_VIEW) trans_r <= view_tr[col_r];
    end
  end

  // ---------------- accumulate / compare ----------------
  always_comb begin
    acc_nxt = ((mul_tag.row == 2'd0) ? AW'(trans_r) : acc_r) + AW'(term);
    if (&acc_nxt[AW-1:31] || ~|acc_nxt[AW-1:31])
      acc_sat = acc_nxt[31:0];
    else
      acc_sat = acc_nxt[AW-1] ? 32'h8000_0000 : 32'h7fff_ffff;
  end

  assign mag_sel    = (mul_tag.kind == fcct_pkg::OP_SLX) ? v_r[0] : v_r[1];
  assign mag_ext    = {mag_sel[31], mag_sel};
  assign mag        = mag_sel[31] ? 33'(-mag_ext) : 33'(mag_ext);
  assign mag_w      = TW'($signed({1'b0, mag}));
  assign within_lim = (mag_w <= term);

  always_ff @(posedge clk) begin
    if (mul_tag.valid) begin
      case (mul_tag.kind)
        fcct_pkg::OP_WORLD: begin
          acc_r <= acc_nxt;
          if (mul_tag.row == 2'd2) w_r[mul_tag.col] <= acc_sat;
        end
        fcct_pkg::OP_VIEW: begin
          acc_r <= acc_nxt;
          if (mul_tag.row == 2'd2) v_r[mul_tag.col] <= acc_sat;
        end
        fcct_pkg::OP_SLX: okx_r <= within_lim;
        fcct_pkg::OP_SLY: oky_r <= within_lim;
        default: ;
      endcase
    end
  end

  // ---------------- sequencer ----------------
  assign in_view = (v_r[2] >= $signed({1'b0, near_r})) &&
                   (v_r[2] <= $signed({1'b0, far_r})) && okx_r && oky_r;
  assign any_nxt = any_inside_r || in_view;

  always_ff @(posedge clk) begin
    if (in_fire && in_chan.action == fcct_pkg::ACT_CORNER) begin
      p_r[0] <= in_chan.corner_x;
      p_r[1] <= in_chan.corner_y;
      p_r[2] <= in_chan.corner_z;
      last_r <= in_chan.last_corner;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      col_r        <= 2'd0;
      row_r        <= 2'd0;
      any_inside_r <= 1'b0;
      out_valid_r  <= 1'b0;
      visible_r    <= 1'b0;
    end else begin
      // a new word from the finish step replaces the one taken this cycle
      if (out_valid_r && out_chan.ready && !(state_r == S_FINISH && last_r))
        out_valid_r <= 1'b0;
      case (state_r)
        S_IDLE: begin
          col_r <= 2'd0;
          row_r <= 2'd0;
          if (in_fire && in_chan.action == fcct_pkg::ACT_CORNER) state_r <= S_WORLD;
        end
        S_WORLD, S_VIEW: begin
          if (row_r == 2'd2) begin
            row_r <= 2'd0;
            if (col_r == 2'd2) begin
              col_r   <= 2'd0;
              state_r <= (state_r == S_WORLD) ? S_VIEW : S_GAP;
            end else begin
              col_r <= col_r + 2'd1;
            end
          end else begin
            row_r <= row_r + 2'd1;
          end
        end
        S_GAP: state_r <= S_SLOPE;  // view z settles here
        S_SLOPE: begin
          if (row_r == 2'd0) begin
            row_r <= 2'd1;
          end else begin
            row_r   <= 2'd0;
            state_r <= S_TAIL;
          end
        end
        S_TAIL: state_r <= S_FINISH;
        S_FINISH: begin
          if (!last_r) begin
            any_inside_r <= any_nxt;
            state_r      <= S_IDLE;
          end else if (out_free) begin
            out_valid_r  <= 1'b1;
            visible_r    <= any_nxt;
            any_inside_r <= 1'b0;
            state_r      <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  // ---------------- assertions ----------------
  a_out_from_finish: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == S_FINISH) && $past(last_r))
    else $error("result word raised outside the finish step");

  a_mul_drained_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_IDLE || state_r == S_FINISH) |-> !mul_tag.valid)
    else $error("multiplier still busy when sequencer is done");

  a_corner_starts: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && in_chan.action == fcct_pkg::ACT_CORNER) |=> state_r == S_WORLD)
    else $error("accepted corner did not start the world transform");

endmodule
